[hdl/pitt_pkg.sv]
// shared types, constants and helpers for the integer to text converter
package pitt_pkg;

    localparam int VALUE_W    = 32;
    localparam int WIDTH_W    = 5;
    localparam int CHAR_W     = 8;
    localparam int DIG_W      = 4;
    localparam int DIGITS_DEC = 10;
    localparam int DIGITS_HEX = 8;
    localparam int BCD_W      = DIGITS_DEC * DIG_W;
    localparam int NDIG_W     = 4;
    localparam int CNT_W      = 5;

    localparam logic [DIG_W-1:0]  DABBLE_LIMIT = 4'd5;
    localparam logic [DIG_W-1:0]  DABBLE_ADD   = 4'd3;
    localparam logic [DIG_W-1:0]  DIGIT_MAX    = 4'd9;
    localparam logic [DIG_W-1:0]  DIGIT_TEN    = 4'd10;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;

    typedef enum logic [1:0] {
        CONV_IDLE,
        CONV_DABBLE,
        CONV_NORM,
        CONV_DONE
    } conv_state_t;

    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] value;
        logic               hex;
        logic [WIDTH_W-1:0] width;
        logic               zpad;
    } conv_req_t;

    typedef struct packed {
        logic               valid;
        logic [BCD_W-1:0]   digits;
        logic [NDIG_W-1:0]  ndig;
        logic [WIDTH_W-1:0] width;
        logic               zpad;
    } conv_res_t;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIG_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d > DIGIT_MAX)
        begin
            c = CHAR_LOWER_A + CHAR_W'(d - DIGIT_TEN);
        end
        else
        begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

[hdl/pitt_ifs.sv]
// valid/ready channel interfaces for numbers in and characters out
interface pitt_in_if;
    import pitt_pkg::*;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               hex_radix;
    logic [WIDTH_W-1:0] field_width;
    logic               zero_pad;

    modport source (output valid, output value, output hex_radix, output field_width,
                    output zero_pad, input ready);
    modport sink (input valid, input value, input hex_radix, input field_width,
                  input zero_pad, output ready);
endinterface

interface pitt_out_if;
    import pitt_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_out;
    logic              last_char;

    modport source (output valid, output char_out, output last_char, input ready);
    modport sink (input valid, input char_out, input last_char, output ready);
endinterface

[hdl/pitt_digit_conv.sv]
// binary to digit converter, bit-serial for decimal, with leading zero removal
module pitt_digit_conv
    import pitt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  conv_req_t req,
    input  logic      take,
    output logic      idle,
    output conv_res_t res
);

    conv_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [VALUE_W-1:0] shift_reg, shift_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [NDIG_W-1:0]  ndig_reg, ndig_next;
    logic [WIDTH_W-1:0] width_reg, width_next;
    logic               zpad_reg, zpad_next;
    logic [BCD_W-1:0]   adj;

    // add-3 correction, one lane per digit
    always_comb
    begin
        for (int i = 0; i < DIGITS_DEC; i++)
        begin
            if (bcd_reg[i*DIG_W +: DIG_W] >= DABBLE_LIMIT)
            begin
                adj[i*DIG_W +: DIG_W] = bcd_reg[i*DIG_W +: DIG_W] + DABBLE_ADD;
            end
            else
            begin
                adj[i*DIG_W +: DIG_W] = bcd_reg[i*DIG_W +: DIG_W];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CONV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
        ndig_reg  <= ndig_next;
        width_reg <= width_next;
        zpad_reg  <= zpad_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        ndig_next  = ndig_reg;
        width_next = width_reg;
        zpad_next  = zpad_reg;
        unique case (state_reg)
            CONV_IDLE:
            begin
                if (req.start)
                begin
                    width_next = req.width;
                    zpad_next  = req.zpad;
                    shift_next = req.value;
                    if (req.hex)
                    begin
                        bcd_next   = {req.value, {(BCD_W-VALUE_W){1'b0}}};
                        ndig_next  = NDIG_W'(DIGITS_HEX);
                        state_next = CONV_NORM;
                    end
                    else
                    begin
                        bcd_next   = '0;
                        ndig_next  = NDIG_W'(DIGITS_DEC);
                        cnt_next   = CNT_W'(VALUE_W - 1);
                        state_next = CONV_DABBLE;
                    end
                end
            end
            CONV_DABBLE:
            begin
                bcd_next   = {adj[BCD_W-2:0], shift_reg[VALUE_W-1]};
                shift_next = {shift_reg[VALUE_W-2:0], 1'b0};
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = CONV_NORM;
                end
            end
            CONV_NORM:
            begin
                // drop one leading zero digit per cycle, keep at least one digit
                if ((ndig_reg > NDIG_W'(1)) && (bcd_reg[BCD_W-1 -: DIG_W] == '0))
                begin
                    bcd_next  = {bcd_reg[BCD_W-DIG_W-1:0], {DIG_W{1'b0}}};
                    ndig_next = ndig_reg - 1'b1;
                end
                else
                begin
                    state_next = CONV_DONE;
                end
            end
            CONV_DONE:
            begin
                if (take)
                begin
                    state_next = CONV_IDLE;
                end
            end
            default:
            begin
                state_next = CONV_IDLE;
            end
        endcase
    end

    assign idle       = (state_reg == CONV_IDLE);
    assign res.valid  = (state_reg == CONV_DONE);
    assign res.digits = bcd_reg;
    assign res.ndig   = ndig_reg;
    assign res.width  = width_reg;
    assign res.zpad   = zpad_reg;

endmodule

[hdl/pitt_char_emit.sv]
// pad and digit character sequencer with registered output
module pitt_char_emit
    import pitt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  conv_res_t res,
    input  logic      take,
    output logic      ready,
    pitt_out_if.source text
);

    logic               busy_reg, busy_next;
    logic               ovalid_reg, ovalid_next;
    logic [BCD_W-1:0]   dig_reg, dig_next;
    logic [NDIG_W-1:0]  ndig_reg, ndig_next;
    logic [WIDTH_W-1:0] npad_reg, npad_next;
    logic               zpad_reg, zpad_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;
    logic               step;

    assign ready = !busy_reg;
    assign step  = busy_reg && (!ovalid_reg || text.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg  <= dig_next;
        ndig_reg <= ndig_next;
        npad_reg <= npad_next;
        zpad_reg <= zpad_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    always_comb
    begin
        busy_next   = busy_reg;
        ovalid_next = ovalid_reg;
        dig_next    = dig_reg;
        ndig_next   = ndig_reg;
        npad_next   = npad_reg;
        zpad_next   = zpad_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        if (ovalid_reg && text.ready)
        begin
            ovalid_next = 1'b0;
        end
        if (take)
        begin
            busy_next = 1'b1;
            dig_next  = res.digits;
            ndig_next = res.ndig;
            zpad_next = res.zpad;
            if (res.width > WIDTH_W'(res.ndig))
            begin
                npad_next = res.width - WIDTH_W'(res.ndig);
            end
            else
            begin
                npad_next = '0;
            end
        end
        else if (step)
        begin
            ovalid_next = 1'b1;
            if (npad_reg != '0)
            begin
                char_next = zpad_reg ? CHAR_ZERO : CHAR_SPACE;
                last_next = 1'b0;
                npad_next = npad_reg - 1'b1;
            end
            else
            begin
                char_next = digit_to_ascii(dig_reg[BCD_W-1 -: DIG_W]);
                dig_next  = {dig_reg[BCD_W-DIG_W-1:0], {DIG_W{1'b0}}};
                ndig_next = ndig_reg - 1'b1;
                last_next = (ndig_reg == NDIG_W'(1));
                if (ndig_reg == NDIG_W'(1))
                begin
                    busy_next = 1'b0;
                end
            end
        end
    end

    assign text.valid     = ovalid_reg;
    assign text.char_out  = char_reg;
    assign text.last_char = last_reg;

endmodule

[hdl/padded_integer_to_text.sv]
// top level: unsigned integer to padded decimal or hex text
//
// channel   role    payload
// number    sink    value[31:0], hex_radix, field_width[4:0], zero_pad
// text      source  char_out[7:0], last_char
//
// decimal conversion shifts one bit per cycle through all 32 bits, then strips one
// leading zero digit per cycle (up to 9); hex skips the shifting (up to 7 strips)
// characters then leave one per cycle from the output register while the text channel
// is ready, and the next number converts meanwhile
// reset clears the control state of converter and emitter; no clearing pass
// a stalled text channel holds the character, then backs up into converter and input
module padded_integer_to_text
    import pitt_pkg::*;
#(
    parameter int MAX_WIDTH = 31
)
(
    input  logic clk,
    input  logic rst_n,
    pitt_in_if.sink    number,
    pitt_out_if.source text
);

    localparam int CMP_W = ($clog2(MAX_WIDTH + 1) > WIDTH_W) ? $clog2(MAX_WIDTH + 1)
                                                             : WIDTH_W;

    conv_req_t          req;
    conv_res_t          res;
    logic               conv_idle;
    logic               emit_ready;
    logic               take;
    logic               accept;
    logic [WIDTH_W-1:0] sat_width;

    // width saturation
    always_comb
    begin
        if (CMP_W'(number.field_width) > CMP_W'(MAX_WIDTH))
        begin
            sat_width = WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            sat_width = number.field_width;
        end
    end

    assign number.ready = conv_idle;
    assign accept       = number.valid && conv_idle;
    assign req.start    = accept;
    assign req.value    = number.value;
    assign req.hex      = number.hex_radix;
    assign req.width    = sat_width;
    assign req.zpad     = number.zero_pad;
    assign take         = res.valid && emit_ready;

    pitt_digit_conv u_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .take  (take),
        .idle  (conv_idle),
        .res   (res)
    );

    pitt_char_emit u_emit (
        .clk   (clk),
        .rst_n (rst_n),
        .res   (res),
        .take  (take),
        .ready (emit_ready),
        .text  (text)
    );

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !number.ready)
        else $error("converter took a new transaction while busy");

    a_emit_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> !emit_ready)
        else $error("emitter did not start after handoff");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !take) |=> (res.valid && $stable(res.digits) && $stable(res.ndig)))
        else $error("converted digits changed before handoff");
`endif

endmodule

[dv/tb_padded_integer_to_text.sv]
// testbench for the padded integer to text converter: directed and random numbers in, characters checked
module tb_padded_integer_to_text;
    import pitt_pkg::*;

    localparam int  MAX_TEXT_WIDTH = 31;
    localparam int  RANDOM_NUMBERS = 400;
    localparam int  CYCLE_LIMIT    = 1000000;
    localparam int  HOLD_CYCLES    = 600;
    localparam int  DRAIN_CYCLES   = 60;
    localparam int  MAX_REPORTS    = 10;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_char_t;

    class text_scoreboard;
        text_char_t pending_chars[$];
        int         mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void note_number(input logic [VALUE_W-1:0] value, input logic hex,
                                  input logic [WIDTH_W-1:0] width, input logic zpad);
            logic [CHAR_W-1:0] digit_chars[$];
            logic [VALUE_W-1:0] v;
            int unsigned        d;
            int                 eff_width;
            int                 npad;
            text_char_t         c;
            v = value;
            do
            begin
                if (hex)
                begin
                    d = 32'(v[3:0]);
                    v = v >> 4;
                end
                else
                begin
                    d = v % 10;
                    v = v / 10;
                end
                if (d > 9)
                    digit_chars.push_front(CHAR_LOWER_A + CHAR_W'(d - 10));
                else
                    digit_chars.push_front(CHAR_ZERO + CHAR_W'(d));
            end
            while (v != 0);
            eff_width = (int'(width) > MAX_TEXT_WIDTH) ? MAX_TEXT_WIDTH : int'(width);
            npad = (eff_width > digit_chars.size()) ? eff_width - digit_chars.size() : 0;
            c.last = 1'b0;
            c.ch   = zpad ? CHAR_ZERO : CHAR_SPACE;
            repeat (npad)
                pending_chars.push_back(c);
            foreach (digit_chars[i])
            begin
                c.ch   = digit_chars[i];
                c.last = (i == digit_chars.size() - 1);
                pending_chars.push_back(c);
            end
        endfunction

        function void check_char(input logic [CHAR_W-1:0] ch, input logic last);
            text_char_t want;
            if (pending_chars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected character %h last %b with nothing pending", ch, last);
            end
            else
            begin
                want = pending_chars.pop_front();
                if (ch !== want.ch || last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("text mismatch: expected char %h last %b, got char %h last %b",
                                 want.ch, want.last, ch, last);
                end
            end
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    pitt_in_if  num_if ();
    pitt_out_if txt_if ();

    padded_integer_to_text u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (num_if),
        .text   (txt_if)
    );

    text_scoreboard sb;
    int             num_gap_max;
    int             text_gap_max;
    int             numbers_sent;
    logic           text_hold;
    int             cycles;

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    task automatic send_number(input logic [VALUE_W-1:0] value, input logic hex,
                               input logic [WIDTH_W-1:0] width, input logic zpad);
        int gap;
        gap = $urandom_range(0, num_gap_max);
        if (gap > 0)
        begin
            @(negedge clk);
            num_if.valid <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
        @(negedge clk);
        num_if.valid       <= 1'b1;
        num_if.value       <= value;
        num_if.hex_radix   <= hex;
        num_if.field_width <= width;
        num_if.zero_pad    <= zpad;
        do
            @(posedge clk);
        while (!num_if.ready);
        sb.note_number(value, hex, width, zpad);
        numbers_sent++;
    endtask

    task automatic send_random_number();
        logic [VALUE_W-1:0] value;
        logic [VALUE_W-1:0] p;
        int                 kind;
        kind = $urandom_range(0, 9);
        p    = 1;
        case (kind)
            5: value = $urandom_range(0, 20);
            6: value = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
            7:
            begin
                repeat ($urandom_range(0, 9))
                    p = p * 10;
                value = p - $urandom_range(0, 1);
            end
            8: value = 32'hffff_ffff - $urandom_range(0, 3);
            9: value = '0;
            default: value = $urandom;
        endcase
        send_number(value, 1'($urandom_range(0, 1)), WIDTH_W'($urandom_range(0, 31)),
                    1'($urandom_range(0, 1)));
    endtask

    // text receiver
    initial
    begin
        int stall;
        txt_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = $urandom_range(0, text_gap_max);
            if (stall > 0 || text_hold)
            begin
                @(negedge clk);
                txt_if.ready <= 1'b0;
                repeat ((stall > 0) ? stall - 1 : 0)
                    @(negedge clk);
                while (text_hold)
                    @(negedge clk);
            end
            @(negedge clk);
            txt_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!txt_if.valid);
            sb.check_char(txt_if.char_out, txt_if.last_char);
        end
    end

    // long receiver hold-off so the converter backs up onto its input
    initial
    begin
        text_hold = 1'b0;
        wait (numbers_sent >= 120);
        text_hold = 1'b1;
        repeat (HOLD_CYCLES)
            @(posedge clk);
        text_hold = 1'b0;
    end

    initial
    begin
        int k;
        sb           = new();
        numbers_sent = 0;
        num_gap_max  = 15;
        text_gap_max = 15;
        rst_n              <= 1'b0;
        num_if.valid       <= 1'b0;
        num_if.value       <= '0;
        num_if.hex_radix   <= 1'b0;
        num_if.field_width <= '0;
        num_if.zero_pad    <= 1'b0;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero value, widths and pad styles
        send_number(32'd0, 1'b0, 5'd0, 1'b0);
        send_number(32'd0, 1'b1, 5'd0, 1'b1);
        send_number(32'd0, 1'b0, 5'd31, 1'b1);
        send_number(32'd0, 1'b1, 5'd31, 1'b0);
        send_number(32'd0, 1'b0, 5'd1, 1'b0);
        // widest values in both radixes
        send_number(32'hffff_ffff, 1'b0, 5'd0, 1'b0);
        send_number(32'hffff_ffff, 1'b1, 5'd0, 1'b1);
        send_number(32'hffff_ffff, 1'b0, 5'd31, 1'b0);
        send_number(32'hffff_ffff, 1'b1, 5'd31, 1'b1);
        // width below digit count
        send_number(32'hffff_ffff, 1'b0, 5'd5, 1'b1);
        send_number(32'h89ab_cdef, 1'b1, 5'd3, 1'b0);
        // digit boundaries
        send_number(32'd9, 1'b0, 5'd2, 1'b1);
        send_number(32'd10, 1'b0, 5'd2, 1'b0);
        send_number(32'd15, 1'b1, 5'd4, 1'b1);
        send_number(32'd16, 1'b1, 5'd4, 1'b0);
        send_number(32'd1000000000, 1'b0, 5'd10, 1'b1);
        send_number(32'd999999999, 1'b0, 5'd11, 1'b0);
        send_number(32'h8000_0000, 1'b1, 5'd8, 1'b1);
        send_number(32'h1234_5678, 1'b1, 5'd9, 1'b0);
        send_number(32'habcd_ef01, 1'b1, 5'd16, 1'b1);
        send_number(32'd1, 1'b0, 5'd30, 1'b0);
        send_number(32'h5555_5555, 1'b0, 5'd0, 1'b1);
        send_number(32'haaaa_aaaa, 1'b1, 5'd0, 1'b0);

        for (k = 0; k < RANDOM_NUMBERS; k++)
        begin
            case ((k / 50) % 4)
                0:
                begin
                    num_gap_max  = 15;
                    text_gap_max = 15;
                end
                1:
                begin
                    num_gap_max  = 0;
                    text_gap_max = 0;
                end
                2:
                begin
                    num_gap_max  = 15;
                    text_gap_max = 0;
                end
                default:
                begin
                    num_gap_max  = 0;
                    text_gap_max = 15;
                end
            endcase
            send_random_number();
        end

        @(negedge clk);
        num_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
